@@ rtl/core/kwc_pkg.sv @@
// ----------------------------------------------------------------------------
// kwc_pkg
// Shared types, constants and the keyword table of the keyword counter.
// ----------------------------------------------------------------------------
package kwc_pkg;

    localparam int NUM_KEYS       = 11;
    localparam int KEY_IDX_W      = 4;
    localparam int CH_W           = 8;
    localparam int PREFIX_CHARS   = 8;
    localparam int PREFIX_IDX_W   = $clog2(PREFIX_CHARS);
    localparam int PREFIX_W       = PREFIX_CHARS * CH_W;
    localparam int KW_LEN_W       = 4;
    localparam int OUT_COUNT_W    = 32;
    localparam int OUT_TDATA_W    = 40;
    localparam int DEF_MAX_WORD   = 100;
    localparam int DEF_COUNT_BITS = 32;

    // Item kinds carried on tuser.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_DUMP = 1'b1;

    typedef logic [PREFIX_W-1:0] prefix_t;
    typedef logic [KW_LEN_W-1:0] kw_len_t;

    // Keywords packed with the first character in the low byte, in sorted order.
    localparam prefix_t KW_PATTERN [NUM_KEYS] = '{
        64'h0000_0000_6F74_7561,   // auto
        64'h0000_006B_6165_7262,   // break
        64'h0000_0000_6573_6163,   // case
        64'h0000_0000_7261_6863,   // char
        64'h0000_0074_736E_6F63,   // const
        64'h6575_6E69_746E_6F63,   // continue
        64'h0074_6C75_6166_6564,   // default
        64'h6465_6E67_6973_6E75,   // unsigned
        64'h0000_0000_6469_6F76,   // void
        64'h656C_6974_616C_6F76,   // volatile
        64'h0000_0065_6C69_6877    // while
    };

    localparam kw_len_t KW_LEN [NUM_KEYS] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd8, 4'd4, 4'd8, 4'd5
    };

    // Word-end event from the word tracker to the counter bank.
    typedef struct packed {
        logic                hit;
        logic [NUM_KEYS-1:0] key_sel;
    } kwc_hit_t;

    function automatic logic is_letter(input logic [CH_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

@@ rtl/core/kwc_word.sv @@
// ----------------------------------------------------------------------------
// kwc_word
// Tracks the open word and reports which keyword, if any, a finished word is.
// ----------------------------------------------------------------------------
module kwc_word
    import kwc_pkg::*;
#(
    parameter int MAX_WORD = DEF_MAX_WORD
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic            op,
    input  logic [CH_W-1:0] ch,
    output kwc_hit_t        hit
);

    localparam int LEN_W = $clog2(MAX_WORD);

    logic             in_word_reg, in_word_next;
    prefix_t          prefix_reg,  prefix_next;
    logic [LEN_W-1:0] len_reg,     len_next;
    logic [NUM_KEYS-1:0] key_match;
    logic             finishing;
    logic             letter;
    logic             alnum;

    assign letter = is_letter(ch);
    assign alnum  = letter || is_digit(ch);

    // Only words of at most eight characters can match; the table lengths see to that.
    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            key_match[k] = in_word_reg && (len_reg == LEN_W'(KW_LEN[k]))
                           && (prefix_reg == KW_PATTERN[k]);
        end
    end

    always_comb
    begin
        in_word_next = in_word_reg;
        prefix_next  = prefix_reg;
        len_next     = len_reg;
        finishing    = 1'b0;
        if (step)
        begin
            if (op == OP_CHAR)
            begin
                if (in_word_reg && alnum)
                begin
                    if (len_reg < LEN_W'(PREFIX_CHARS))
                    begin
                        prefix_next[CH_W*len_reg[PREFIX_IDX_W-1:0] +: CH_W] = ch;
                    end
                    len_next = len_reg + 1'b1;
                    // A word cut at the length limit is too long to be a keyword.
                    if (len_reg == LEN_W'(MAX_WORD - 2))
                    begin
                        in_word_next = 1'b0;
                        prefix_next  = '0;
                        len_next     = '0;
                    end
                end
                else
                begin
                    finishing    = in_word_reg;
                    in_word_next = letter;
                    prefix_next  = letter ? prefix_t'(ch) : '0;
                    len_next     = letter ? LEN_W'(1) : '0;
                end
            end
            else
            begin
                finishing    = in_word_reg;
                in_word_next = 1'b0;
                prefix_next  = '0;
                len_next     = '0;
            end
        end
    end

    always_comb
    begin
        hit.key_sel = finishing ? key_match : '0;
        hit.hit     = |hit.key_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg <= 1'b0;
            prefix_reg  <= '0;
            len_reg     <= '0;
        end
        else
        begin
            in_word_reg <= in_word_next;
            prefix_reg  <= prefix_next;
            len_reg     <= len_next;
        end
    end

endmodule

@@ rtl/core/keyword_occurrence_counter.sv @@
// ----------------------------------------------------------------------------
// keyword_occurrence_counter
// Counts whole-word occurrences of eleven keywords in a byte stream.
// ----------------------------------------------------------------------------
// Character beats (tuser = 0) are taken one per clock with no output while no
// dump beat waits in the input register; a word ending on a character is
// counted once its beat leaves the input register. A dump beat (tuser = 1)
// closes any open word, copies all counters into a dump buffer, clears them
// and sends eleven beats, index 0 to 10, the last with tlast, by way of the
// output register. Character beats keep flowing while a dump is being sent; a
// second dump beat waits in the input register, with the beats behind it,
// until the buffer has handed its last count to the output register.
// The output register lets the input side run while m_axis_tready is low.
module keyword_occurrence_counter
    import kwc_pkg::*;
#(
    parameter int MAX_WORD   = DEF_MAX_WORD,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [CH_W-1:0]        s_axis_tdata,   // [7:0] ch
    input  logic [0:0]             s_axis_tuser,   // [0] op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [3:0] key_index, [35:4] key_count
    output logic                   m_axis_tlast    // last
);

    typedef logic [COUNT_BITS-1:0] count_t;

    logic            in_valid_reg, in_valid_next;
    logic            in_op_reg;
    logic [CH_W-1:0] in_ch_reg;
    logic            stall;
    logic            step;
    logic            accept;
    logic            dump_now;
    kwc_hit_t        hit;

    count_t cnt_reg [NUM_KEYS];
    count_t cnt_next [NUM_KEYS];
    count_t cnt_inc [NUM_KEYS];
    count_t buf_reg [NUM_KEYS];

    logic                 dump_busy_reg, dump_busy_next;
    logic [KEY_IDX_W-1:0] emit_idx_reg,  emit_idx_next;
    logic                 out_load;
    logic                 emit_last;

    logic                   m_valid_reg, m_valid_next;
    logic [KEY_IDX_W-1:0]   m_idx_reg;
    logic [OUT_COUNT_W-1:0] m_count_reg;
    logic                   m_last_reg;
    logic [OUT_COUNT_W-1:0] emit_count;

    // Input register.
    assign stall         = in_valid_reg && (in_op_reg == OP_DUMP) && dump_busy_reg;
    assign step          = in_valid_reg && !stall;
    assign s_axis_tready = !in_valid_reg || !stall;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign dump_now      = step && (in_op_reg == OP_DUMP);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_op_reg <= s_axis_tuser[0];
            in_ch_reg <= s_axis_tdata;
        end
    end

    kwc_word #(
        .MAX_WORD (MAX_WORD)
    ) u_word (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .op    (in_op_reg),
        .ch    (in_ch_reg),
        .hit   (hit)
    );

    // Saturating counters; a dump captures them after the closing word is counted.
    always_comb
    begin
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            cnt_inc[k]  = (hit.hit && hit.key_sel[k] && (cnt_reg[k] != '1))
                          ? cnt_reg[k] + 1'b1 : cnt_reg[k];
            cnt_next[k] = dump_now ? '0 : cnt_inc[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dump_now)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                buf_reg[k] <= cnt_inc[k];
            end
        end
    end

    // Dump sequencer feeding the output register.
    assign out_load  = dump_busy_reg && (!m_valid_reg || m_axis_tready);
    assign emit_last = (emit_idx_reg == KEY_IDX_W'(NUM_KEYS - 1));

    generate
        if (COUNT_BITS >= OUT_COUNT_W)
        begin : g_count_trunc
            assign emit_count = buf_reg[emit_idx_reg][OUT_COUNT_W-1:0];
        end
        else
        begin : g_count_ext
            assign emit_count = {{(OUT_COUNT_W-COUNT_BITS){1'b0}}, buf_reg[emit_idx_reg]};
        end
    endgenerate

    always_comb
    begin
        dump_busy_next = dump_busy_reg;
        emit_idx_next  = emit_idx_reg;
        if (dump_now)
        begin
            dump_busy_next = 1'b1;
            emit_idx_next  = '0;
        end
        else if (out_load)
        begin
            if (emit_last)
            begin
                dump_busy_next = 1'b0;
                emit_idx_next  = '0;
            end
            else
            begin
                emit_idx_next = emit_idx_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dump_busy_reg <= 1'b0;
            emit_idx_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            dump_busy_reg <= dump_busy_next;
            emit_idx_reg  <= emit_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_idx_reg   <= emit_idx_reg;
            m_count_reg <= emit_count;
            m_last_reg  <= emit_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_COUNT_W-KEY_IDX_W){1'b0}}, m_count_reg, m_idx_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

@@ tb/keyword_occurrence_counter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyword_occurrence_counter_tb
// Self-checking testbench for the keyword occurrence counter. A byte stream
// of keywords, near misses, long words and noise is fed through the input
// stream. A scoreboard tracks word state and per-keyword counts on every
// accepted character. On a dump it queues the eleven expected count beats,
// and it checks each beat that leaves the output stream against them.
// ----------------------------------------------------------------------------
module keyword_occurrence_counter_tb;
    import kwc_pkg::*;

    localparam int WORD_LIMIT   = DEF_MAX_WORD;
    localparam int ITEMS        = 420;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [KEY_IDX_W-1:0]   key_index;
        logic [OUT_COUNT_W-1:0] key_count;
        logic                   last;
    } count_beat_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [CH_W-1:0]        s_axis_tdata;   // [7:0] ch
    logic [0:0]             s_axis_tuser;   // [0] op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [3:0] key_index, [35:4] key_count
    logic                   m_axis_tlast;   // last

    int   sent;
    int   idle_cycles;
    bit   calm;
    bit   hold_request;

    string kw_text [NUM_KEYS] = '{"auto", "break", "case", "char", "const", "continue",
                                  "default", "unsigned", "void", "volatile", "while"};

    function automatic bit ascii_letter(logic [CH_W-1:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit ascii_alnum(logic [CH_W-1:0] c);
        return ascii_letter(c) || (c >= "0" && c <= "9");
    endfunction

    class keyword_scoreboard;
        bit                        open_word;
        prefix_t                   prefix;
        logic [6:0]                length;
        logic [DEF_COUNT_BITS-1:0] tally [NUM_KEYS];
        count_beat_t               pending [$];
        int                        errors;

        function new();
            open_word = 1'b0;
            prefix    = '0;
            length    = '0;
            errors    = 0;
            foreach (tally[k])
                tally[k] = '0;
        endfunction

        function void close_word();
            if (open_word && length <= PREFIX_CHARS)
            begin
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    if (KW_LEN[k] == length && KW_PATTERN[k] == prefix)
                    begin
                        if (tally[k] != '1)
                            tally[k] = tally[k] + 1'b1;
                        break;
                    end
                end
            end
            open_word = 1'b0;
            prefix    = '0;
            length    = '0;
        endfunction

        function void push_char(logic [CH_W-1:0] ch);
            if (length < PREFIX_CHARS)
                prefix[8*length +: 8] = ch;
            length = length + 7'd1;
        endfunction

        function void note_input(logic op, logic [CH_W-1:0] ch);
            count_beat_t beat;
            if (op == OP_CHAR)
            begin
                if (open_word && ascii_alnum(ch))
                begin
                    push_char(ch);
                    // Overlong words are cut and judged at the limit.
                    if (length >= WORD_LIMIT - 1)
                        close_word();
                end
                else
                begin
                    if (open_word)
                        close_word();
                    if (ascii_letter(ch))
                    begin
                        open_word = 1'b1;
                        push_char(ch);
                    end
                end
            end
            else
            begin
                close_word();
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    beat.key_index = KEY_IDX_W'(k);
                    beat.key_count = tally[k][OUT_COUNT_W-1:0];
                    beat.last      = (k == NUM_KEYS - 1);
                    pending.push_back(beat);
                    tally[k] = '0;
                end
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
            count_beat_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual data=%h last=%b",
                         $time, data, last);
                return;
            end
            want = pending.pop_front();
            if (data[KEY_IDX_W-1:0] !== want.key_index)
            begin
                errors++;
                $display("%0t: key_index mismatch, expected %0d actual %0d",
                         $time, want.key_index, data[KEY_IDX_W-1:0]);
            end
            if (data[KEY_IDX_W +: OUT_COUNT_W] !== want.key_count)
            begin
                errors++;
                $display("%0t: key_count mismatch at index %0d, expected %0d actual %0d",
                         $time, want.key_index, want.key_count,
                         data[KEY_IDX_W +: OUT_COUNT_W]);
            end
            if (data[OUT_TDATA_W-1:KEY_IDX_W+OUT_COUNT_W] !== '0)
            begin
                errors++;
                $display("%0t: tdata padding mismatch, expected 0 actual %h",
                         $time, data[OUT_TDATA_W-1:KEY_IDX_W+OUT_COUNT_W]);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: tlast mismatch at index %0d, expected %b actual %b",
                         $time, want.key_index, want.last, last);
            end
        endfunction
    endclass

    keyword_scoreboard scoreboard = new();

    keyword_occurrence_counter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CH_W-1:0] random_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? CH_W'(8'h41 + r) : CH_W'(8'h61 + r - 26);
    endfunction

    function automatic logic [CH_W-1:0] random_alnum();
        int r;
        r = $urandom_range(0, 61);
        return (r < 10) ? CH_W'(8'h30 + r) : random_letter();
    endfunction

    function automatic logic [CH_W-1:0] random_separator();
        logic [CH_W-1:0] c;
        do
            c = CH_W'($urandom_range(0, 255));
        while (ascii_alnum(c));
        return c;
    endfunction

    function automatic logic [CH_W-1:0] random_byte();
        return CH_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CH_W-1:0] random_digit();
        return CH_W'(8'h30 + $urandom_range(0, 9));
    endfunction

    // Offers one beat, holds it until taken, then maybe leaves a short gap.
    task automatic send_item(input logic op, input logic [CH_W-1:0] ch);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= ch;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        scoreboard.note_input(op, ch);
        sent++;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(OP_CHAR, s[i]);
    endtask

    task automatic send_word(input int len);
        send_item(OP_CHAR, random_letter());
        for (int i = 1; i < len; i++)
            send_item(OP_CHAR, random_alnum());
    endtask

    // Receiver: random short stalls, one long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            scoreboard.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        if (rst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int  r;
        int  k;
        int  tail;
        int  long_words;
        bit  held;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_CHAR;
        sent          = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        hold_request  = 1'b0;
        long_words    = 0;
        held          = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: NUL and high bytes as separators, a digit ahead of a word,
        // upper case, a word closed by the dump, then a dump of cleared counts.
        send_text("char");
        send_item(OP_CHAR, 8'h00);
        send_text("1while");
        send_item(OP_CHAR, 8'hFF);
        send_text("CASE");
        send_item(OP_CHAR, 8'h80);
        send_text("volatile");
        send_item(OP_DUMP, 8'hFF);
        send_item(OP_DUMP, 8'h00);

        while (sent < ITEMS)
        begin
            calm = (sent > ITEMS - 60);
            k    = $urandom_range(0, NUM_KEYS - 1);
            if (!held && sent > 180)
            begin
                // Stall the output while dumps pile up behind it.
                held = 1'b1;
                hold_request = 1'b1;
                send_text("while ");
                repeat (3) send_item(OP_DUMP, random_byte());
            end
            else if (long_words < 2 && sent > 90 + 150 * long_words)
            begin
                long_words++;
                send_word($urandom_range(WORD_LIMIT - 3, WORD_LIMIT + 1));
                if ($urandom_range(0, 1))
                    send_item(OP_CHAR, random_digit());
                send_text(kw_text[k]);
                send_item(OP_CHAR, random_separator());
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    send_text(kw_text[k]);
                    tail = $urandom_range(0, 9);
                    if (tail == 6)
                        send_item(OP_CHAR, random_digit());
                    else if (tail == 7)
                        send_item(OP_CHAR, random_letter());
                    if (tail <= 7)
                        send_item(OP_CHAR, random_separator());
                    else if (tail == 9)
                        send_item(OP_DUMP, random_byte());
                end
                else if (r < 55)
                begin
                    send_word($urandom_range(1, 12));
                    send_item(OP_CHAR, random_separator());
                end
                else if (r < 70)
                    send_item(OP_CHAR, random_byte());
                else if (r < 75)
                begin
                    send_text(kw_text[k].toupper());
                    send_item(OP_CHAR, random_separator());
                end
                else if (r < 80)
                begin
                    send_text(kw_text[k].substr(0, $urandom_range(0, kw_text[k].len() - 2)));
                    send_item(OP_CHAR, random_separator());
                end
                else if (r < 85)
                begin
                    repeat ($urandom_range(1, 3)) send_item(OP_CHAR, random_digit());
                    send_text(kw_text[k]);
                    send_item(OP_CHAR, random_separator());
                end
                else if (r < 95)
                    send_item(OP_DUMP, random_byte());
                else
                begin
                    send_item(OP_CHAR, random_letter());
                    send_text(kw_text[k]);
                    send_item(OP_CHAR, random_separator());
                end
            end
        end

        calm = 1'b1;
        send_item(OP_DUMP, random_byte());
        s_axis_tvalid <= 1'b0;
        while (scoreboard.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (scoreboard.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
